### rtl/mte_pkg.sv
// Shared constants and types for the MIDI track event encoder.
// Used by the top level, the tempo divider and the port checker.
// No dependencies.
package mte_pkg;

    // Field widths
    localparam int TIME_W  = 28;
    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 3;
    localparam int LEN_W   = 2;
    localparam int IN_TDATA_W = 56;

    // Event kinds
    localparam logic [KIND_W-1:0] KIND_CHAN  = 3'd0;
    localparam logic [KIND_W-1:0] KIND_KEY   = 3'd1;
    localparam logic [KIND_W-1:0] KIND_TSIG  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TEMPO = 3'd3;
    localparam logic [KIND_W-1:0] KIND_EOT   = 3'd4;

    // Meta event bytes
    localparam logic [BYTE_W-1:0] META_MARK      = 8'hFF;
    localparam logic [BYTE_W-1:0] META_KEY       = 8'h59;
    localparam logic [BYTE_W-1:0] META_TSIG      = 8'h58;
    localparam logic [BYTE_W-1:0] META_SET_TEMPO = 8'h51;
    localparam logic [BYTE_W-1:0] META_EOT       = 8'h2F;
    localparam logic [BYTE_W-1:0] LEN_KEY     = 8'h02;
    localparam logic [BYTE_W-1:0] LEN_TSIG    = 8'h04;
    localparam logic [BYTE_W-1:0] LEN_TEMPO   = 8'h03;
    localparam logic [BYTE_W-1:0] LEN_EOT     = 8'h00;
    localparam logic [BYTE_W-1:0] TSIG_CLOCKS = 8'd18;
    localparam logic [BYTE_W-1:0] TSIG_32NDS  = 8'd8;
    localparam logic [BYTE_W-1:0] LB_CAP      = 8'd5;
    localparam logic [BYTE_W-1:0] VLQ_MORE    = 8'h80;

    // Body lengths in bytes, after the delta
    localparam logic [2:0] BODY_KEY   = 3'd5;
    localparam logic [2:0] BODY_TSIG  = 3'd7;
    localparam logic [2:0] BODY_TEMPO = 3'd6;
    localparam logic [2:0] BODY_EOT   = 3'd3;

    // Tempo divider: microseconds per minute over bpm
    localparam int DIV_W = 26;
    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] US_PER_MIN = 26'd60000000;
    localparam logic [23:0] TEMPO_ZERO_BPM = 24'hFFFFFF;

    // Divider status towards the sequencer
    typedef struct packed {
        logic                 busy;
        logic [DIV_W-1:0]     quotient;
    } t_div_status;

    // Least n in 0..4 with 2^n >= b, else capped at 5
    function automatic logic [BYTE_W-1:0] beat_log2(input logic [BYTE_W-1:0] b);
        logic [BYTE_W-1:0] lb;
        if (b <= 8'd1)       lb = 8'd0;
        else if (b <= 8'd2)  lb = 8'd1;
        else if (b <= 8'd4)  lb = 8'd2;
        else if (b <= 8'd8)  lb = 8'd3;
        else if (b <= 8'd16) lb = 8'd4;
        else                 lb = LB_CAP;
        return lb;
    endfunction

    // Number of variable-length bytes for a 28-bit delta
    function automatic logic [2:0] vlq_len(input logic [TIME_W-1:0] d);
        logic [2:0] n;
        if (d[27:21] != 7'd0)      n = 3'd4;
        else if (d[20:14] != 7'd0) n = 3'd3;
        else if (d[13:7] != 7'd0)  n = 3'd2;
        else                       n = 3'd1;
        return n;
    endfunction

endpackage

### rtl/mte_div.sv
// Restoring divider for the tempo value: a fixed dividend over an 8-bit bpm.
// One quotient bit per cycle through a single 9-bit subtract and compare.
// Depends on mte_pkg.
module mte_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [mte_pkg::BYTE_W-1:0] i_divisor,
    output mte_pkg::t_div_status      o_status
);

    logic                        r_busy;
    logic [mte_pkg::CNT_W-1:0]   r_cnt;
    logic [mte_pkg::BYTE_W-1:0]  r_rem;
    logic [mte_pkg::BYTE_W-1:0]  r_dvs;
    logic [mte_pkg::DIV_W-1:0]   r_quo;

    logic [mte_pkg::BYTE_W:0]    w_trial;
    logic [mte_pkg::BYTE_W:0]    w_diff;
    logic                        w_ge;

    // Shared subtract and compare for one step
    always_comb begin
        w_trial = {r_rem, r_quo[mte_pkg::DIV_W-1]};
        w_diff  = w_trial - {1'b0, r_dvs};
        w_ge    = (w_trial >= {1'b0, r_dvs});
    end

    // Control: busy flag and step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= mte_pkg::CNT_W'(mte_pkg::DIV_W - 1);
        end else if (r_busy) begin
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end else begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    // Datapath: remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= mte_pkg::US_PER_MIN;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[mte_pkg::BYTE_W-1:0] : w_trial[mte_pkg::BYTE_W-1:0];
            r_quo <= {r_quo[mte_pkg::DIV_W-2:0], w_ge};
        end
    end

    assign o_status.busy     = r_busy;
    assign o_status.quotient = r_quo;

endmodule

### rtl/midi_track_event_encoder.sv
// MIDI track event encoder: one timed event in, its track bytes out, one byte per cycle
// unless the output stalls or a tempo byte waits on the divider. The first byte is
// registered once in S_EMIT with the output slot free. Items are taken only in S_IDLE,
// so a new item waits for the current one's last byte. A tempo event with a non-zero bpm
// holds its last three bytes for the 26-step divider; empty items give no output. Reset
// (synchronous, active low) clears the kept time to 0 and empties the output register.
module midi_track_event_encoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    // [27:0] event_time, [29:28] msg_len, [37:30] data_a, [45:38] data_b,
    // [53:46] data_c, [55:54] zero
    input  logic [mte_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // [2:0] kind
    input  logic [mte_pkg::KIND_W-1:0]       i_s_tuser,
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    // [7:0] out_byte
    output logic [mte_pkg::BYTE_W-1:0]       o_m_tdata,
    output logic                             o_m_tlast
);

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state                       r_state;
    logic [mte_pkg::TIME_W-1:0]   r_track;
    logic [mte_pkg::TIME_W-1:0]   r_delta;
    logic [mte_pkg::KIND_W-1:0]   r_kind;
    logic [mte_pkg::BYTE_W-1:0]   r_a;
    logic [mte_pkg::BYTE_W-1:0]   r_b;
    logic [mte_pkg::BYTE_W-1:0]   r_c;
    logic [2:0]                   r_nb;
    logic [3:0]                   r_idx;
    logic                         r_o_valid;
    logic [mte_pkg::BYTE_W-1:0]   r_o_byte;
    logic                         r_o_last;

    // Input fields
    logic [mte_pkg::TIME_W-1:0]   w_time;
    logic [mte_pkg::LEN_W-1:0]    w_len;
    logic [mte_pkg::BYTE_W-1:0]   w_a;
    logic [mte_pkg::BYTE_W-1:0]   w_b;
    logic [mte_pkg::BYTE_W-1:0]   w_c;
    logic [mte_pkg::KIND_W-1:0]   w_kind;
    logic                         w_accept;
    logic                         w_has_out;
    logic                         w_timed;
    logic [2:0]                   w_nb;

    // Emission
    logic                         w_slot_free;
    logic [2:0]                   w_nv;
    logic [3:0]                   w_total;
    logic [3:0]                   w_j;
    logic [2:0]                   w_g;
    logic [6:0]                   w_grp;
    logic [23:0]                  w_us;
    logic [mte_pkg::BYTE_W-1:0]   w_byte;
    logic                         w_hold;
    logic                         w_last;

    mte_pkg::t_div_status         w_div;
    logic                         w_div_start;

    assign w_time = i_s_tdata[27:0];
    assign w_len  = i_s_tdata[29:28];
    assign w_a    = i_s_tdata[37:30];
    assign w_b    = i_s_tdata[45:38];
    assign w_c    = i_s_tdata[53:46];
    assign w_kind = i_s_tuser;

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;

    // Decode the accepted item
    always_comb begin
        w_has_out = 1'b1;
        w_timed   = 1'b1;
        w_nb      = 3'd0;
        case (w_kind)
            mte_pkg::KIND_CHAN: begin
                w_has_out = (w_len != '0);
                w_timed   = (w_len != '0);
                w_nb      = {1'b0, w_len};
            end
            mte_pkg::KIND_KEY:   w_nb = mte_pkg::BODY_KEY;
            mte_pkg::KIND_TSIG:  w_nb = mte_pkg::BODY_TSIG;
            mte_pkg::KIND_TEMPO: w_nb = mte_pkg::BODY_TEMPO;
            mte_pkg::KIND_EOT: begin
                w_timed = 1'b0;
                w_nb    = mte_pkg::BODY_EOT;
            end
            default: begin
                w_has_out = 1'b0;
                w_timed   = 1'b0;
            end
        endcase
    end

    assign w_div_start = w_accept && (w_kind == mte_pkg::KIND_TEMPO) && (w_a != '0);

    mte_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (w_a),
        .o_status  (w_div)
    );

    // Byte selection for the current index
    always_comb begin
        w_slot_free = !r_o_valid || i_m_tready;
        w_nv        = mte_pkg::vlq_len(r_delta);
        w_total     = {1'b0, w_nv} + {1'b0, r_nb};
        w_j         = r_idx - {1'b0, w_nv};
        w_g         = w_nv - 3'd1 - r_idx[2:0];
        w_us        = (r_a == '0) ? mte_pkg::TEMPO_ZERO_BPM : w_div.quotient[23:0];
        w_last      = (r_idx == (w_total - 4'd1));
        w_hold      = 1'b0;
        case (w_g[1:0])
            2'd0:    w_grp = r_delta[6:0];
            2'd1:    w_grp = r_delta[13:7];
            2'd2:    w_grp = r_delta[20:14];
            default: w_grp = r_delta[27:21];
        endcase
        w_byte = '0;
        if (r_idx < {1'b0, w_nv}) begin
            w_byte = (w_g[1:0] != 2'd0) ? (mte_pkg::VLQ_MORE | {1'b0, w_grp})
                                        : {1'b0, w_grp};
        end else begin
            case (r_kind)
                mte_pkg::KIND_CHAN: begin
                    case (w_j)
                        4'd0:    w_byte = r_a;
                        4'd1:    w_byte = r_b;
                        default: w_byte = r_c;
                    endcase
                end
                mte_pkg::KIND_KEY: begin
                    case (w_j)
                        4'd0:    w_byte = mte_pkg::META_MARK;
                        4'd1:    w_byte = mte_pkg::META_KEY;
                        4'd2:    w_byte = mte_pkg::LEN_KEY;
                        4'd3:    w_byte = r_a;
                        default: w_byte = r_b;
                    endcase
                end
                mte_pkg::KIND_TSIG: begin
                    case (w_j)
                        4'd0:    w_byte = mte_pkg::META_MARK;
                        4'd1:    w_byte = mte_pkg::META_TSIG;
                        4'd2:    w_byte = mte_pkg::LEN_TSIG;
                        4'd3:    w_byte = r_a;
                        4'd4:    w_byte = mte_pkg::beat_log2(r_b);
                        4'd5:    w_byte = mte_pkg::TSIG_CLOCKS;
                        default: w_byte = mte_pkg::TSIG_32NDS;
                    endcase
                end
                mte_pkg::KIND_TEMPO: begin
                    // tempo value bytes wait for the divider
                    w_hold = (w_j >= 4'd3) && w_div.busy;
                    case (w_j)
                        4'd0:    w_byte = mte_pkg::META_MARK;
                        4'd1:    w_byte = mte_pkg::META_SET_TEMPO;
                        4'd2:    w_byte = mte_pkg::LEN_TEMPO;
                        4'd3:    w_byte = w_us[23:16];
                        4'd4:    w_byte = w_us[15:8];
                        default: w_byte = w_us[7:0];
                    endcase
                end
                default: begin
                    case (w_j)
                        4'd0:    w_byte = mte_pkg::META_MARK;
                        4'd1:    w_byte = mte_pkg::META_EOT;
                        default: w_byte = mte_pkg::LEN_EOT;
                    endcase
                end
            endcase
        end
    end

    // Sequencer, kept time and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_track   <= '0;
            r_o_valid <= 1'b0;
            r_idx     <= '0;
        end else begin
            if (r_o_valid && i_m_tready) begin
                r_o_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && w_has_out) begin
                        r_state <= S_EMIT;
                        r_idx   <= '0;
                        r_kind  <= w_kind;
                        r_nb    <= w_nb;
                        r_a     <= w_a;
                        r_b     <= w_b;
                        r_c     <= w_c;
                        if (w_timed && (w_time > r_track)) begin
                            r_delta <= w_time - r_track;
                        end else begin
                            r_delta <= '0;
                        end
                        if (w_timed) begin
                            r_track <= w_time;
                        end
                    end
                end
                S_EMIT: begin
                    if (w_slot_free && !w_hold) begin
                        r_o_valid <= 1'b1;
                        r_o_byte  <= w_byte;
                        r_o_last  <= w_last;
                        r_idx     <= r_idx + 4'd1;
                        if (w_last) begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_o_valid;
    assign o_m_tdata  = r_o_byte;
    assign o_m_tlast  = r_o_last;

endmodule

### rtl/mte_checker.sv
// Port-level checks for the MIDI track event encoder, bound to the top level.
// Depends on mte_pkg and midi_track_event_encoder.
module mte_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             i_s_tvalid,
    input logic                             o_s_tready,
    input logic [mte_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    input logic [mte_pkg::KIND_W-1:0]       i_s_tuser,
    input logic                             o_m_tvalid,
    input logic                             i_m_tready,
    input logic [mte_pkg::BYTE_W-1:0]       o_m_tdata,
    input logic                             o_m_tlast
);

    logic w_in_acc;
    assign w_in_acc = i_s_tvalid && o_s_tready;

    // A stalled byte holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && !i_m_tready) |=> (o_m_tvalid && $stable(o_m_tdata)
                                         && $stable(o_m_tlast)))
        else $error("output byte changed while stalled");

    // A meta event keeps the input closed while its bytes go out
    a_meta_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && (i_s_tuser == mte_pkg::KIND_KEY || i_s_tuser == mte_pkg::KIND_TSIG
                      || i_s_tuser == mte_pkg::KIND_TEMPO || i_s_tuser == mte_pkg::KIND_EOT))
        |=> !o_s_tready)
        else $error("input ready during a meta event");

    // An empty channel message is dropped at once
    a_empty_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_s_tuser == mte_pkg::KIND_CHAN && i_s_tdata[29:28] == 2'd0)
        |=> o_s_tready)
        else $error("empty channel message held the input");

    // When idle, a waiting byte can only be the end of the previous event
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_s_tready && o_m_tvalid) |-> o_m_tlast)
        else $error("idle with a non-final byte waiting");

endmodule

bind midi_track_event_encoder mte_checker u_mte_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tdata  (i_s_tdata),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);
